// ===== hdl/cbsm_pkg.sv =====
// cbsm_pkg: shared types and constants of the cartridge bank switch mapper
// no dependencies; imported by every module of the block

package cbsm_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PRG   = 2'd1;
  localparam logic [1:0] CMD_CHR   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

  localparam int CFG_WIDTH     = 9;
  localparam int NUM_BANK_REGS = 8;

  localparam logic [CFG_WIDTH-1:0] PRG_COUNT_RESET = 9'd32;
  localparam logic [CFG_WIDTH-1:0] CHR_COUNT_RESET = 9'd128;

  // cpu write decode: address bits 15..13 and 0
  localparam logic [15:0] DECODE_MASK   = 16'hE001;
  localparam logic [15:0] ADDR_BANK_SEL = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DAT = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR   = 16'hA000;
  localparam logic [15:0] ADDR_RAM_CTL  = 16'hA001;
  localparam logic [15:0] ADDR_IRQ_LAT  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RLD  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_DIS  = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_EN   = 16'hE001;

  // ram control codes from data bits 7..6
  localparam logic [1:0] RAM_BOTH_ON = 2'd2;
  localparam logic [1:0] RAM_RD_ONLY = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } cbsm_in_t;

  typedef struct packed {
    logic [7:0] bank;
    logic       mirror_horizontal;
    logic       ram_read_enable;
    logic       ram_write_enable;
    logic [7:0] irq_reload_value;
    logic       irq_enabled;
    logic       irq_reload_pulse;
    logic       irq_ack_pulse;
  } cbsm_out_t;

  // mapper control state apart from the bank registers
  typedef struct packed {
    logic [2:0] select_index;
    logic       prg_mode;
    logic       chr_mode;
    logic       mirror;
    logic       ram_rd;
    logic       ram_wr;
    logic [7:0] irq_latch;
    logic       irq_on;
  } cbsm_ctrl_t;

  localparam cbsm_ctrl_t CTRL_RESET = '{
    select_index: 3'd0, prg_mode: 1'b0, chr_mode: 1'b0, mirror: 1'b0,
    ram_rd: 1'b1, ram_wr: 1'b1, irq_latch: 8'd0, irq_on: 1'b0
  };

endpackage

// ===== hdl/cartridge_bank_switch_mapper_unit.sv =====
// cartridge_bank_switch_mapper_unit: top level, input and result registers
// depends on cbsm_pkg, cbsm_regs, cbsm_xlate
//
//   channel | ports                              | word
//   input   | in_valid, in_ready, in_word        | cbsm_in_t
//   result  | out_valid, out_ready, out_word     | cbsm_out_t
//   config  | cfg_we, cfg_index, cfg_data        | 9-bit register value
//
// one word per cycle unless a stalled result holds the flow; an accepted word waits in
// the input register, and its result then sits in the result register until taken.
// the decode, state update and bank mux sit between those two registers.
// rst_n is synchronous; mapper state returns to its power-on values.
// a stalled result holds the input register, and in_ready drops only when
// both registers are full and out_ready is low.

module cartridge_bank_switch_mapper_unit #(
  parameter int BANK_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cbsm_pkg::cbsm_in_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cbsm_pkg::cbsm_out_t            out_word,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [cbsm_pkg::CFG_WIDTH-1:0] cfg_data
);
  import cbsm_pkg::*;

  logic       s1_valid_r, out_valid_r;
  cbsm_in_t   s1_word_r;
  cbsm_out_t  out_word_r, out_word_nxt;
  logic       adv, s1_fire;

  cbsm_ctrl_t ctrl, ctrl_nxt;
  logic [NUM_BANK_REGS-1:0][BANK_WIDTH-1:0] banks;
  logic [CFG_WIDTH-1:0] prg_count;
  logic       reload_pulse, ack_pulse;
  logic [7:0] bank;

  // handshake
  assign adv      = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  cbsm_regs #(.BANK_WIDTH(BANK_WIDTH)) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .upd          (s1_fire),
    .item         (s1_word_r),
    .ctrl         (ctrl),
    .ctrl_nxt     (ctrl_nxt),
    .banks        (banks),
    .prg_count    (prg_count),
    .reload_pulse (reload_pulse),
    .ack_pulse    (ack_pulse)
  );

  cbsm_xlate #(.BANK_WIDTH(BANK_WIDTH)) u_xlate (
    .item      (s1_word_r),
    .ctrl      (ctrl),
    .banks     (banks),
    .prg_count (prg_count),
    .bank      (bank)
  );

  // result word shows state after the word
  always_comb begin
    out_word_nxt.bank              = bank;
    out_word_nxt.mirror_horizontal = ctrl_nxt.mirror;
    out_word_nxt.ram_read_enable   = ctrl_nxt.ram_rd;
    out_word_nxt.ram_write_enable  = ctrl_nxt.ram_wr;
    out_word_nxt.irq_reload_value  = ctrl_nxt.irq_latch;
    out_word_nxt.irq_enabled       = ctrl_nxt.irq_on;
    out_word_nxt.irq_reload_pulse  = reload_pulse;
    out_word_nxt.irq_ack_pulse     = ack_pulse;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_word_r <= in_word;
    if (s1_fire) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/cbsm_regs.sv =====
// cbsm_regs: configuration registers, cpu write decode and mapper state
// depends on cbsm_pkg

module cbsm_regs #(
  parameter int BANK_WIDTH = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic [1:0]                                  cfg_index,
  input  logic [cbsm_pkg::CFG_WIDTH-1:0]              cfg_data,
  input  logic                                        upd,
  input  cbsm_pkg::cbsm_in_t                          item,
  output cbsm_pkg::cbsm_ctrl_t                        ctrl,
  output cbsm_pkg::cbsm_ctrl_t                        ctrl_nxt,
  output logic [cbsm_pkg::NUM_BANK_REGS-1:0][BANK_WIDTH-1:0] banks,
  output logic [cbsm_pkg::CFG_WIDTH-1:0]              prg_count,
  output logic                                        reload_pulse,
  output logic                                        ack_pulse
);
  import cbsm_pkg::*;

  logic [CFG_WIDTH-1:0] prg_count_r, chr_count_r;
  logic                 four_screen_r;
  cbsm_ctrl_t           ctrl_r;
  logic [NUM_BANK_REGS-1:0][BANK_WIDTH-1:0] banks_r;

  logic                 is_write;
  logic [15:0]          dec_addr;
  logic [CFG_WIDTH-1:0] count_sel, top, val9, clamp9;
  logic [7:0]           bank_val;
  logic                 bank_we;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r   <= PRG_COUNT_RESET;
      chr_count_r   <= CHR_COUNT_RESET;
      four_screen_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRG_COUNT) prg_count_r <= cfg_data;
      if (cfg_index == CFG_CHR_COUNT) chr_count_r <= cfg_data;
      if (cfg_index == CFG_FOUR_SCREEN) four_screen_r <= cfg_data[0];
    end
  end

  assign is_write = (item.cmd == CMD_WRITE);
  assign dec_addr = item.address & DECODE_MASK;

  // bank data clamp: mask by highest bank when above it; bit 0 cleared for registers 0 and 1
  always_comb begin
    count_sel = (ctrl_r.select_index >= 3'd6) ? prg_count_r : chr_count_r;
    top       = (count_sel == '0) ? '0 : count_sel - 9'd1;
    val9      = {1'b0, item.data_byte};
    clamp9    = (val9 > top) ? (val9 & top) : val9;
    bank_val  = clamp9[7:0];
    if (ctrl_r.select_index < 3'd2) bank_val[0] = 1'b0;
  end

  // write decode into next control state
  always_comb begin
    ctrl_nxt     = ctrl_r;
    bank_we      = 1'b0;
    reload_pulse = 1'b0;
    ack_pulse    = 1'b0;
    if (is_write) begin
      unique case (dec_addr)
        ADDR_BANK_SEL: begin
          ctrl_nxt.select_index = item.data_byte[2:0];
          ctrl_nxt.prg_mode     = item.data_byte[6];
          ctrl_nxt.chr_mode     = item.data_byte[7];
        end
        ADDR_BANK_DAT: bank_we = 1'b1;
        ADDR_MIRROR: begin
          if (!four_screen_r) ctrl_nxt.mirror = item.data_byte[0];
        end
        ADDR_RAM_CTL: begin
          unique case (item.data_byte[7:6])
            RAM_BOTH_ON: begin
              ctrl_nxt.ram_rd = 1'b1;
              ctrl_nxt.ram_wr = 1'b1;
            end
            RAM_RD_ONLY: begin
              ctrl_nxt.ram_rd = 1'b1;
              ctrl_nxt.ram_wr = 1'b0;
            end
            default: begin
              ctrl_nxt.ram_rd = 1'b0;
              ctrl_nxt.ram_wr = 1'b0;
            end
          endcase
        end
        ADDR_IRQ_LAT: ctrl_nxt.irq_latch = item.data_byte;
        ADDR_IRQ_RLD: reload_pulse = 1'b1;
        ADDR_IRQ_DIS: begin
          ctrl_nxt.irq_on = 1'b0;
          ack_pulse       = 1'b1;
        end
        ADDR_IRQ_EN: ctrl_nxt.irq_on = 1'b1;
        default: ;
      endcase
    end
  end

  // state update when a word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= CTRL_RESET;
      banks_r <= '0;
    end else if (upd) begin
      ctrl_r <= ctrl_nxt;
      if (bank_we) banks_r[ctrl_r.select_index] <= bank_val[BANK_WIDTH-1:0];
    end
  end

  assign ctrl      = ctrl_r;
  assign banks     = banks_r;
  assign prg_count = prg_count_r;

endmodule

// ===== hdl/cbsm_xlate.sv =====
// cbsm_xlate: program and character address to physical bank mux
// depends on cbsm_pkg

module cbsm_xlate #(
  parameter int BANK_WIDTH = 8
) (
  input  cbsm_pkg::cbsm_in_t                          item,
  input  cbsm_pkg::cbsm_ctrl_t                        ctrl,
  input  logic [cbsm_pkg::NUM_BANK_REGS-1:0][BANK_WIDTH-1:0] banks,
  input  logic [cbsm_pkg::CFG_WIDTH-1:0]              prg_count,
  output logic [7:0]                                  bank
);
  import cbsm_pkg::*;

  logic [NUM_BANK_REGS-1:0][7:0] banks_ext;
  logic [7:0] before_last, last, prg_bank, chr_bank;
  logic [1:0] prg_slot;
  logic [2:0] chr_slot;

  // zero-extend stored banks to the output width
  always_comb begin
    for (int i = 0; i < NUM_BANK_REGS; i++) begin
      banks_ext[i] = 8'(banks[i]);
    end
  end

  // program slots; fixed banks wrap modulo 256
  assign before_last = prg_count[7:0] - 8'd2;
  assign last        = prg_count[7:0] - 8'd1;
  assign prg_slot    = item.address[14:13];

  always_comb begin
    unique case (prg_slot)
      2'd0:    prg_bank = ctrl.prg_mode ? before_last : banks_ext[6];
      2'd1:    prg_bank = banks_ext[7];
      2'd2:    prg_bank = ctrl.prg_mode ? banks_ext[6] : before_last;
      default: prg_bank = last;
    endcase
  end

  // character slots, upper and lower halves swapped in mode 1
  assign chr_slot = item.address[12:10] ^ {ctrl.chr_mode, 2'b00};

  always_comb begin
    unique case (chr_slot)
      3'd0, 3'd1: chr_bank = {banks_ext[0][7:1], chr_slot[0]};
      3'd2, 3'd3: chr_bank = {banks_ext[1][7:1], chr_slot[0]};
      3'd4:       chr_bank = banks_ext[2];
      3'd5:       chr_bank = banks_ext[3];
      3'd6:       chr_bank = banks_ext[4];
      default:    chr_bank = banks_ext[5];
    endcase
  end

  always_comb begin
    unique case (item.cmd)
      CMD_PRG: bank = prg_bank;
      CMD_CHR: bank = chr_bank;
      default: bank = 8'd0;
    endcase
  end

endmodule
